### rtl/assert_macros.svh
// Assertion macros shared by the crop window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crop window assertion failed");

// Next-cycle implication, disabled during reset.
`define RMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crop window assertion failed");

`endif

### rtl/rmcw_pkg.sv
// Package: constants and result type for the ROI mask to crop window block.
package rmcw_pkg;

    localparam int COLUMN_WORDS  = 40;
    localparam int ROW_WORDS     = 23;
    localparam int SENSOR_WIDTH  = 1280;
    localparam int SENSOR_HEIGHT = 720;
    localparam int TOTAL_WORDS   = COLUMN_WORDS + ROW_WORDS;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 6;
    localparam int X_W    = 11;
    localparam int Y_W    = 10;
    localparam int ROW_IDX_W = 5;
    localparam int BIT_IDX_W = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [WORD_W-1:0] crop_end_word;
        logic [WORD_W-1:0] crop_start_word;
    } crop_res_t;

endpackage

### rtl/rmcw_track.sv
// Mask word tracker: window bounds state and crop result for the last word.
`include "assert_macros.svh"

module rmcw_track
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [rmcw_pkg::WORD_W-1:0]   mask_word,
    input  logic                          word_last,
    output logic                          push,
    output rmcw_pkg::crop_res_t           res
);
    import rmcw_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             col_seen_reg, col_seen_next;
    logic [X_W-1:0]   col_first_reg, col_first_next;
    logic [X_W-1:0]   col_final_reg, col_final_next;
    logic             row_seen_reg, row_seen_next;
    logic [Y_W-1:0]   row_first_reg, row_first_next;
    logic [Y_W-1:0]   row_final_reg, row_final_next;

    logic                 in_range;
    logic                 is_col;
    logic [CNT_W:0]       row_off;
    logic [WORD_W-1:0]    en;
    logic [BIT_IDX_W-1:0] lo;
    logic [BIT_IDX_W-1:0] hi;
    logic [X_W-1:0]       xs, xe;
    logic [Y_W-1:0]       ys, ye;
    logic                 full;

    always_comb
    begin
        cnt_next       = cnt_reg;
        col_seen_next  = col_seen_reg;
        col_first_next = col_first_reg;
        col_final_next = col_final_reg;
        row_seen_next  = row_seen_reg;
        row_first_next = row_first_reg;
        row_final_next = row_final_reg;

        in_range = (cnt_reg != CNT_MAX)
                   && ({2'b00, cnt_reg} < (CNT_W+2)'(TOTAL_WORDS));
        is_col   = {1'b0, cnt_reg} < (CNT_W+1)'(COLUMN_WORDS);
        row_off  = {1'b0, cnt_reg} - (CNT_W+1)'(COLUMN_WORDS);

        en = ~mask_word;
        // only the low half of the final row word holds rows
        if (row_off == (CNT_W+1)'(ROW_WORDS - 1))
        begin
            en[WORD_W-1:WORD_W/2] = '0;
        end

        hi = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (en[j])
            begin
                hi = BIT_IDX_W'(j);
            end
        end
        lo = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (en[j])
            begin
                lo = BIT_IDX_W'(j);
            end
        end

        if (accept)
        begin
            if (in_range)
            begin
                if (is_col)
                begin
                    if (mask_word != '1)
                    begin
                        if (!col_seen_reg)
                        begin
                            col_first_next = {cnt_reg, 5'b00000};
                            col_seen_next  = 1'b1;
                        end
                        col_final_next = {cnt_reg, 5'b11111};
                    end
                end
                else if (en != '0)
                begin
                    if (!row_seen_reg)
                    begin
                        row_first_next = {row_off[ROW_IDX_W-1:0], lo};
                        row_seen_next  = 1'b1;
                    end
                    row_final_next = {row_off[ROW_IDX_W-1:0], hi};
                end
            end
            if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        xs = col_first_next;
        xe = col_final_next;
        ys = row_first_next;
        ye = row_final_next;
        full = (xs == '0) && (xe == X_W'(SENSOR_WIDTH - 1))
               && (ys == '0) && (ye == Y_W'(SENSOR_HEIGHT - 1));
        if (full || !col_seen_next || !row_seen_next)
        begin
            xs = '0;
            xe = '0;
            ys = '0;
            ye = '0;
        end
        else if (ys == ye)
        begin
            // single row: grow down from row zero, otherwise up
            if (ys == '0)
            begin
                ye = Y_W'(1);
            end
            else
            begin
                ys = ys - Y_W'(1);
            end
        end

        res.crop_start_word = {6'b0, ys, 5'b0, xs};
        res.crop_end_word   = {6'b0, ye, 5'b0, xe};
        push = accept && word_last;

        if (accept && word_last)
        begin
            cnt_next       = '0;
            col_seen_next  = 1'b0;
            col_first_next = '0;
            col_final_next = '0;
            row_seen_next  = 1'b0;
            row_first_next = '0;
            row_final_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            col_seen_reg  <= 1'b0;
            col_first_reg <= '0;
            col_final_reg <= '0;
            row_seen_reg  <= 1'b0;
            row_first_reg <= '0;
            row_final_reg <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            col_seen_reg  <= col_seen_next;
            col_first_reg <= col_first_next;
            col_final_reg <= col_final_next;
            row_seen_reg  <= row_seen_next;
            row_first_reg <= row_first_next;
            row_final_reg <= row_final_next;
        end
    end

    `RMCW_ASSERT_NEXT(a_clear_after_last, clk, rst_n, accept && word_last, cnt_reg == '0 && !col_seen_reg && !row_seen_reg)
    `RMCW_ASSERT_NEXT(a_count_step, clk, rst_n, accept && !word_last && cnt_reg != CNT_MAX, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `RMCW_ASSERT_IMPL(a_col_order, clk, rst_n, col_seen_reg, col_first_reg <= col_final_reg)

endmodule

### rtl/rmcw_out_buf.sv
// Result register with a skid stage toward the output channel.
`include "assert_macros.svh"

module rmcw_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rmcw_pkg::crop_res_t push_data,
    output logic                ready,
    output logic                out_valid,
    output rmcw_pkg::crop_res_t out_data,
    input  logic                out_ready
);
    import rmcw_pkg::*;

    logic      out_valid_reg;
    crop_res_t out_data_reg;
    logic      skid_valid_reg;
    crop_res_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        if (push && !skid_valid_reg)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `RMCW_ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `RMCW_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, skid_valid_reg, !push)
    `RMCW_ASSERT_IMPL(a_skid_fill_on_stall, clk, rst_n, $rose(skid_valid_reg), $past(out_valid_reg && !out_ready && push))

endmodule

### rtl/roi_mask_to_crop_window.sv
// Top level: ROI mask word stream in, packed crop window words out.
//
//  channel | dir | tdata                                  | tlast
//  s_*     | in  | [31:0] mask_word                       | word_last
//  m_*     | out | [31:0] crop_start_word, [63:32] end    | -
//
// One mask word per cycle while s_tready is high; the tracker handles each beat in the cycle it is taken.
// The result of a last-marked beat is registered into the output register, or into the skid stage if m_* stalls.
// A second result can park in the skid stage while m_tready is low; s_tready
// drops only while that skid stage is occupied.
// Reset clears the bounds state, the word count and both output stages.
module roi_mask_to_crop_window
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rmcw_pkg::WORD_W-1:0]     s_tdata,   // [31:0] mask_word
    input  logic                            s_tlast,   // word_last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*rmcw_pkg::WORD_W-1:0]   m_tdata    // [31:0] crop_start_word, [63:32] crop_end_word
);
    import rmcw_pkg::*;

    logic      accept;
    logic      push;
    crop_res_t res;
    crop_res_t out_data;

    assign accept = s_tvalid && s_tready;

    rmcw_track u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mask_word (s_tdata),
        .word_last (s_tlast),
        .push      (push),
        .res       (res)
    );

    rmcw_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = out_data;

endmodule

### test/tb_roi_mask_to_crop_window.sv
// Testbench for roi_mask_to_crop_window: random mask streams checked against a crop predictor.
`timescale 1ns / 100ps

import rmcw_pkg::*;

class crop_scoreboard;
    logic [CNT_W-1:0] mask_pos;
    logic             col_seen;
    logic [X_W-1:0]   col_lo;
    logic [X_W-1:0]   col_hi;
    logic             row_seen;
    logic [Y_W-1:0]   row_lo;
    logic [Y_W-1:0]   row_hi;
    crop_res_t        crop_q[$];
    int               fails;

    function new();
        fails = 0;
        clear_mask();
    endfunction

    function void clear_mask();
        mask_pos = '0;
        col_seen = 1'b0;
        col_lo   = '0;
        col_hi   = '0;
        row_seen = 1'b0;
        row_lo   = '0;
        row_hi   = '0;
    endfunction

    // Update bounds for one accepted mask beat; on the last beat queue the crop window.
    function void note_word(logic [WORD_W-1:0] w, logic last);
        int                idx;
        int                r;
        int                lo;
        int                hi;
        logic [WORD_W-1:0] en;
        logic [X_W-1:0]    xs;
        logic [X_W-1:0]    xe;
        logic [Y_W-1:0]    ys;
        logic [Y_W-1:0]    ye;
        logic              full;
        crop_res_t         res;

        idx = mask_pos;
        if (idx < CNT_MAX && idx < TOTAL_WORDS) begin
            if (idx < COLUMN_WORDS) begin
                if (w != '1) begin
                    if (!col_seen) begin
                        col_lo   = X_W'(idx * WORD_W);
                        col_seen = 1'b1;
                    end
                    col_hi = X_W'(idx * WORD_W + WORD_W - 1);
                end
            end
            else begin
                r  = idx - COLUMN_WORDS;
                en = ~w;
                // only the low half of the final row word maps to sensor rows
                if (r == ROW_WORDS - 1)
                    en[31:16] = '0;
                if (en != '0) begin
                    lo = -1;
                    hi = 0;
                    for (int j = 0; j < WORD_W; j++) begin
                        if (en[j]) begin
                            hi = j;
                            if (lo < 0)
                                lo = j;
                        end
                    end
                    if (!row_seen) begin
                        row_lo   = Y_W'(r * WORD_W + lo);
                        row_seen = 1'b1;
                    end
                    row_hi = Y_W'(r * WORD_W + hi);
                end
            end
        end
        if (mask_pos != CNT_MAX)
            mask_pos = mask_pos + 1'b1;
        if (!last)
            return;

        xs = col_lo;
        xe = col_hi;
        ys = row_lo;
        ye = row_hi;
        full = (xs == 0) && (xe == SENSOR_WIDTH - 1) && (ys == 0) && (ye == SENSOR_HEIGHT - 1);
        if (full || !col_seen || !row_seen) begin
            xs = '0;
            xe = '0;
            ys = '0;
            ye = '0;
        end
        else if (ys == ye) begin
            if (ys == 0)
                ye = ys + 1'b1;
            else
                ys = ys - 1'b1;
        end
        res.crop_start_word = {6'd0, ys, 5'd0, xs};
        res.crop_end_word   = {6'd0, ye, 5'd0, xe};
        crop_q = {crop_q, res};
        clear_mask();
    endfunction

    function void check_crop(logic [2*WORD_W-1:0] data);
        crop_res_t got;
        crop_res_t want;

        got = data;
        if (crop_q.size() == 0) begin
            $error("unexpected crop beat %h", data);
            fails++;
            return;
        end
        want = crop_q.pop_front();
        if (got.crop_start_word !== want.crop_start_word) begin
            $error("crop_start_word mismatch: expected %h, actual %h",
                   want.crop_start_word, got.crop_start_word);
            fails++;
        end
        if (got.crop_end_word !== want.crop_end_word) begin
            $error("crop_end_word mismatch: expected %h, actual %h",
                   want.crop_end_word, got.crop_end_word);
            fails++;
        end
    endfunction

    function int pending();
        return crop_q.size();
    endfunction
endclass

module tb_roi_mask_to_crop_window;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_MASK    = 80;
    localparam int ITEM_TARGET = 1350;
    localparam int MASK_TARGET = 30;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata;     // [31:0] mask_word
    logic                  s_tlast;     // word_last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [2*WORD_W-1:0]   m_tdata;     // [31:0] crop_start_word, [63:32] crop_end_word

    crop_scoreboard        sb;
    logic [WORD_W-1:0]     mask_words[MAX_MASK];
    bit                    calm;
    bit                    hold_req;
    bit                    hold_taken;
    int                    hold_left;
    int                    idle_cycles;
    int                    words_sent;
    int                    masks_sent;

    roi_mask_to_crop_window dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_beat(input logic [WORD_W-1:0] w, input logic last);
        while (!calm && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(w, last);
    endtask

    task automatic send_mask(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_beat(mask_words[i], i == len - 1);
            words_sent++;
        end
        masks_sent++;
    endtask

    // Column words cl..ch and rows rl..rh enabled; a negative lower bound enables none.
    task automatic build_mask(input int cl, input int ch, input int rl, input int rh);
        for (int i = 0; i < MAX_MASK; i++)
            mask_words[i] = (i < TOTAL_WORDS) ? '1 : $urandom;
        // rows past the sensor bottom are don't-care bits
        mask_words[TOTAL_WORDS-1][31:16] = 16'($urandom);
        if (cl >= 0)
        begin
            for (int c = cl; c <= ch; c++)
                mask_words[c] = $urandom_range(1) ? '0 : ($urandom & ~(32'd1 << $urandom_range(31)));
        end
        if (rl >= 0)
        begin
            for (int n = rl; n <= rh; n++)
            begin
                if (n == rl || n == rh || $urandom_range(1))
                    mask_words[COLUMN_WORDS + n / WORD_W][n % WORD_W] = 1'b0;
            end
        end
    endtask

    initial
    begin
        m_tready   <= 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_crop(m_tdata);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                m_tready   <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int len;
        int cl;
        int ch;
        int rl;
        int rh;

        sb          = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        words_sent  = 0;
        masks_sent  = 0;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: whole sensor, nothing, columns only, single rows at both edges, all rows but the last
        build_mask(0, COLUMN_WORDS - 1, 0, SENSOR_HEIGHT - 1);
        send_mask(TOTAL_WORDS);
        build_mask(-1, 0, -1, 0);
        send_mask(TOTAL_WORDS);
        build_mask(3, 17, -1, 0);
        send_mask(TOTAL_WORDS);
        build_mask(5, 5, 0, 0);
        send_mask(TOTAL_WORDS);
        build_mask(COLUMN_WORDS - 1, COLUMN_WORDS - 1, SENSOR_HEIGHT - 1, SENSOR_HEIGHT - 1);
        send_mask(TOTAL_WORDS);
        build_mask(0, COLUMN_WORDS - 1, 0, SENSOR_HEIGHT - 2);
        send_mask(TOTAL_WORDS);
        // one-beat masks with all-zero and all-one words
        mask_words[0] = '0;
        send_mask(1);
        mask_words[0] = '1;
        send_mask(1);
        // overlong mask: beats past the end must be ignored
        build_mask(10, 30, 100, 600);
        send_mask(MAX_MASK);

        // back-pressure: sink holds off while one-beat masks pile up
        hold_req = 1'b1;
        calm     = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            mask_words[0] = $urandom;
            send_mask(1);
        end
        calm = 1'b0;

        for (int k = 0; words_sent < ITEM_TARGET || masks_sent < MASK_TARGET; k++)
        begin
            calm = (k >= 8 && k < 14);
            pick = $urandom_range(99);
            cl   = $urandom_range(COLUMN_WORDS - 1);
            ch   = $urandom_range(COLUMN_WORDS - 1, cl);
            rl   = $urandom_range(SENSOR_HEIGHT - 1);
            rh   = ($urandom_range(4) == 0) ? rl : $urandom_range(SENSOR_HEIGHT - 1, rl);
            if (pick < 5)
            begin
                cl = 0;
                ch = COLUMN_WORDS - 1;
                rl = 0;
                rh = SENSOR_HEIGHT - 1;
            end
            else if (pick < 10)
                cl = -1;
            else if (pick < 15)
                rl = -1;
            build_mask(cl, ch, rl, rh);
            if (pick >= 92)
            begin
                for (int i = 0; i < MAX_MASK; i++)
                    mask_words[i] = $urandom;
            end
            pick = $urandom_range(99);
            if (pick < 65)
                len = TOTAL_WORDS;
            else if (pick < 88)
                len = $urandom_range(TOTAL_WORDS - 1, 1);
            else
                len = $urandom_range(MAX_MASK, TOTAL_WORDS + 1);
            send_mask(len);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### roi_mask_to_crop_window.f
+incdir+rtl
rtl/rmcw_pkg.sv
rtl/rmcw_track.sv
rtl/rmcw_out_buf.sv
rtl/roi_mask_to_crop_window.sv
test/tb_roi_mask_to_crop_window.sv
